@@ rtl/core/medmm_pkg.sv @@
// ============================================================================
// medmm_pkg
// Shared sizes, sample type and controller/datapath interface structs for
// the median, minimum and maximum block.
// ============================================================================
package medmm_pkg;

    // Store capacity and sample width
    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_BITS = 32;

    // Held-count and store-address widths
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);

    // Stream data widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SAMPLES);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ld;         // latch the incoming beat, pos <= count
        logic drop;       // store full: discard sample, mark set as overflowed
        logic rd_prev;    // read entry pos-1
        logic shift;      // move read entry up to pos, pos <= pos-1
        logic ins;        // write sample at pos, bump count, track min/max
        logic rd_mid_hi;  // read entry count/2
        logic rd_mid_lo;  // read entry count/2-1
        logic take_hi;    // capture upper middle entry (median when odd)
        logic take_mean;  // median <= floor mean of both middle entries
        logic emit;       // load output register, empty the store
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_last;    // tlast of the beat on the input port
        logic last_q;     // latched tlast of the sample being inserted
        logic full;       // store holds MAX_SAMPLES entries
        logic empty;      // store holds nothing
        logic gt;         // entry read back is greater than the sample
        logic pos_one;    // insertion position is 1
        logic odd;        // held count is odd
        logic out_free;   // output register can take a new result
    } t_status;

endpackage

@@ rtl/core/median_min_max_of_samples.sv @@
// ============================================================================
// median_min_max_of_samples
// Collects a set of signed Q16.16 samples in sorted order and returns the
// median, minimum and maximum when the set closes.
// ============================================================================
// One sample is taken per input beat and inserted into a 64-entry sorted
// store by compare-and-shift through a RAM with one write and one registered
// read port, so each step of the shift reads an entry, then compares and
// moves it. The input stays closed until the sample is placed; the shift
// ends without a further read when the sample becomes the new smallest
// entry, the first sample of a set is written at once, and a sample that
// finds the store full is dropped. A beat with tlast set closes the set; the
// middle entries (one or two) are read before the result beat is loaded,
// one result per set. The median of an even count is the floor of the mean
// of the two middle samples. Samples beyond 64 are dropped and flagged in
// tuser. A new set may begin while the previous result waits on the output.
// ============================================================================
module median_min_max_of_samples
    import medmm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] sample
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] median, [63:32] min, [95:64] max
    output logic                 m_tuser    // [0] overflowed
);

    t_cmd    w_cmd;
    t_status w_status;

    medmm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    medmm_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .i_s_tdata (s_tdata),
        .i_s_tlast (s_tlast),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

endmodule

@@ rtl/core/medmm_ram.sv @@
// ============================================================================
// medmm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module medmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/medmm_datapath.sv @@
// ============================================================================
// medmm_datapath
// Sorted sample store, insertion position, count, running min/max, median
// arithmetic and the output register.
// ============================================================================
module medmm_datapath
    import medmm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic                 o_m_tuser
);

    // Control registers
    logic             r_valid, n_valid;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_dropped, n_dropped;

    // Payload registers
    logic [CNT_W-1:0] r_pos, n_pos;
    t_sample          r_sample, n_sample;
    logic             r_last, n_last;
    t_sample          r_min, n_min;
    t_sample          r_max, n_max;
    t_sample          r_hi, n_hi;
    t_sample          r_med, n_med;
    t_sample          r_o_med, n_o_med;
    t_sample          r_o_min, n_o_min;
    t_sample          r_o_max, n_o_max;
    logic             r_o_ovf, n_o_ovf;

    // Store access
    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [SAMPLE_BITS-1:0] w_wdata;
    logic [ADDR_W-1:0]      w_raddr;
    logic [SAMPLE_BITS-1:0] w_rdata;
    t_sample                w_rd;
    logic [CNT_W-1:0]       w_half;
    logic [SAMPLE_BITS:0]   w_sum;

    medmm_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd   = t_sample'(w_rdata);
    assign w_half = r_count >> 1;

    // Pick the read address
    always_comb begin
        w_raddr = '0;
        if (i_cmd.rd_prev) begin
            w_raddr = ADDR_W'(r_pos - CNT_W'(1));
        end else if (i_cmd.rd_mid_hi) begin
            w_raddr = ADDR_W'(w_half);
        end else if (i_cmd.rd_mid_lo) begin
            w_raddr = ADDR_W'(w_half - CNT_W'(1));
        end
    end

    // Write either a shifted entry or the new sample at pos
    assign w_we    = i_cmd.shift | i_cmd.ins;
    assign w_waddr = ADDR_W'(r_pos);
    assign w_wdata = i_cmd.shift ? w_rdata : r_sample;

    // Floor mean of the two middle entries: sign-extended sum, drop the LSB
    assign w_sum = {w_rd[SAMPLE_BITS-1], w_rd} + {r_hi[SAMPLE_BITS-1], r_hi};

    // Next-state logic
    always_comb begin
        n_valid   = r_valid & ~i_m_tready;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_pos     = r_pos;
        n_sample  = r_sample;
        n_last    = r_last;
        n_min     = r_min;
        n_max     = r_max;
        n_hi      = r_hi;
        n_med     = r_med;
        n_o_med   = r_o_med;
        n_o_min   = r_o_min;
        n_o_max   = r_o_max;
        n_o_ovf   = r_o_ovf;

        if (i_cmd.ld) begin
            n_pos    = r_count;
            n_sample = t_sample'(i_s_tdata[SAMPLE_BITS-1:0]);
            n_last   = i_s_tlast;
        end
        if (i_cmd.drop) begin
            n_dropped = 1'b1;
        end
        if (i_cmd.shift) begin
            n_pos = r_pos - CNT_W'(1);
        end
        if (i_cmd.ins) begin
            n_count = r_count + CNT_W'(1);
            if (r_count == '0) begin
                n_min = r_sample;
                n_max = r_sample;
            end else begin
                if (r_sample < r_min) n_min = r_sample;
                if (r_sample > r_max) n_max = r_sample;
            end
        end
        if (i_cmd.take_hi) begin
            n_hi  = w_rd;
            n_med = w_rd;
        end
        if (i_cmd.take_mean) begin
            n_med = t_sample'(w_sum[SAMPLE_BITS:1]);
        end
        if (i_cmd.emit) begin
            n_valid   = 1'b1;
            n_o_med   = r_med;
            n_o_min   = r_min;
            n_o_max   = r_max;
            n_o_ovf   = r_dropped;
            n_count   = '0;
            n_dropped = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_sample <= n_sample;
        r_last   <= n_last;
        r_min    <= n_min;
        r_max    <= n_max;
        r_hi     <= n_hi;
        r_med    <= n_med;
        r_o_med  <= n_o_med;
        r_o_min  <= n_o_min;
        r_o_max  <= n_o_max;
        r_o_ovf  <= n_o_ovf;
    end

    // Status back to the controller
    assign o_status.in_last  = i_s_tlast;
    assign o_status.last_q   = r_last;
    assign o_status.full     = (r_count == CNT_FULL);
    assign o_status.empty    = (r_count == '0);
    assign o_status.gt       = (w_rd > r_sample);
    assign o_status.pos_one  = (r_pos == CNT_W'(1));
    assign o_status.odd      = r_count[0];
    assign o_status.out_free = ~r_valid | i_m_tready;

    // Output beat
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = M_TDATA_W'({r_o_max, r_o_min, r_o_med});
    assign o_m_tuser  = r_o_ovf;

endmodule

@@ rtl/core/medmm_ctrl.sv @@
// ============================================================================
// medmm_ctrl
// Sequencer for insertion, median readout and result hand-off.
// ============================================================================
module medmm_ctrl
    import medmm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD     = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_WR     = 3'd3;
    localparam logic [2:0] S_MID_RD = 3'd4;
    localparam logic [2:0] S_MID_A  = 3'd5;
    localparam logic [2:0] S_MID_B  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0] r_state, n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid & o_s_tready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.ld = 1'b1;
                    if (i_status.full) begin
                        o_cmd.drop = 1'b1;
                        n_state    = i_status.in_last ? S_MID_RD : S_IDLE;
                    end else if (i_status.empty) begin
                        n_state = S_WR;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = S_CMP;
            end
            S_CMP: begin
                // Move a larger neighbor up, or stop at this position
                if (i_status.gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = i_status.pos_one ? S_WR : S_RD;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.ins = 1'b1;
                n_state   = i_status.last_q ? S_MID_RD : S_IDLE;
            end
            S_MID_RD: begin
                o_cmd.rd_mid_hi = 1'b1;
                n_state         = S_MID_A;
            end
            S_MID_A: begin
                o_cmd.take_hi = 1'b1;
                if (i_status.odd) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_mid_lo = 1'b1;
                    n_state         = S_MID_B;
                end
            end
            S_MID_B: begin
                o_cmd.take_mean = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/medmm_checker.sv @@
// ============================================================================
// medmm_checker
// Port-level checks for the median, minimum and maximum block.
// ============================================================================
module medmm_checker
    import medmm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 i_s_tready,
    input logic                 i_s_tlast,
    input logic                 i_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] i_m_tdata
);

    t_sample w_med, w_min, w_max;

    assign w_med = t_sample'(i_m_tdata[SAMPLE_BITS-1:0]);
    assign w_min = t_sample'(i_m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign w_max = t_sample'(i_m_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);

    // A stalled result beat stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

    // Median lies between minimum and maximum
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (w_min <= w_med) && (w_med <= w_max))
        else $error("median outside min/max range");

    // A closing beat leaves the input closed right after it is accepted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready && i_s_tlast |=> !i_s_tready)
        else $error("input ready right after a closing beat");

endmodule

bind median_min_max_of_samples medmm_checker u_medmm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(s_tvalid),
    .i_s_tready(s_tready),
    .i_s_tlast (s_tlast),
    .i_m_tvalid(m_tvalid),
    .i_m_tready(m_tready),
    .i_m_tdata (m_tdata)
);
